/* rtl/core/assert_macros.svh */
// Assertion macros shared by the CSV field splitter RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/csvfs_pkg.sv */
// Shared types and constants for the CSV field splitter.
// Depends on nothing; used by every module of the block.
`default_nettype none

package csvfs_pkg;

    localparam int BYTE_W  = 8;
    localparam int FIELD_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

    localparam logic [BYTE_W-1:0] SEP_RESET = 8'd44;

    localparam logic [CFG_IDX_W-1:0] REG_SEP_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_SECOND = 2'd1;

    typedef enum logic [2:0] {
        MODE_LINE_START  = 3'd0,
        MODE_FIELD_START = 3'd1,
        MODE_PLAIN       = 3'd2,
        MODE_QUOTED      = 3'd3,
        MODE_QUOTE_SEEN  = 3'd4,
        MODE_RAW         = 3'd5
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_input;
    } item_t;

    typedef struct packed {
        logic               has_byte;
        logic [BYTE_W-1:0]  out_byte;
        logic [FIELD_W-1:0] field_index;
        logic               field_done;
        logic               line_done;
        logic               empty_line;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/csvfs_in_stage.sv */
// Input register of the CSV field splitter: holds one accepted transaction.
// Depends on csvfs_pkg.
`default_nettype none

module csvfs_in_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire csvfs_pkg::item_t item,
    input  wire logic            step_go,
    output logic                 item_vld,
    output csvfs_pkg::item_t     item_held
);

    logic             vld_reg;
    logic             vld_next;
    csvfs_pkg::item_t item_reg;

    // The slot frees up in the same cycle that its item is consumed.
    assign in_ready = !vld_reg || step_go;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
        else if (step_go)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item;
        end
    end

    assign item_vld  = vld_reg;
    assign item_held = item_reg;

endmodule

`default_nettype wire

/* rtl/core/csvfs_core.sv */
// Parser state, separator registers and the one-byte step logic.
// Depends on csvfs_pkg.
`default_nettype none

module csvfs_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [csvfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [csvfs_pkg::BYTE_W-1:0]        cfg_data,
    input  wire logic                                step_go,
    input  wire csvfs_pkg::item_t                    item,
    output logic                                     res_valid,
    output csvfs_pkg::result_t                       res
);

    logic [csvfs_pkg::BYTE_W-1:0]  sep_first_reg;
    logic [csvfs_pkg::BYTE_W-1:0]  sep_second_reg;
    csvfs_pkg::mode_t              mode_reg;
    csvfs_pkg::mode_t              mode_next;
    logic [csvfs_pkg::FIELD_W-1:0] field_reg;
    logic [csvfs_pkg::FIELD_W-1:0] field_next;
    logic                          cr_reg;
    logic                          cr_next;

    logic b_is_sep;
    logic b_is_quote;
    logic b_is_eol;
    logic at_line_start;
    logic [csvfs_pkg::FIELD_W-1:0] field_inc;

    assign b_is_sep   = (item.in_byte == sep_first_reg) || (item.in_byte == sep_second_reg);
    assign b_is_quote = (item.in_byte == csvfs_pkg::CH_QUOTE);
    assign b_is_eol   = (item.in_byte == csvfs_pkg::CH_CR) || (item.in_byte == csvfs_pkg::CH_LF);
    // Unused mode codes behave as line start.
    assign at_line_start = (mode_reg == csvfs_pkg::MODE_LINE_START) ||
                           (mode_reg > csvfs_pkg::MODE_RAW);
    assign field_inc = (field_reg == '1) ? field_reg : field_reg + 1'b1;

    always_comb
    begin
        mode_next  = mode_reg;
        field_next = field_reg;
        cr_next    = 1'b0;
        res_valid  = 1'b0;
        res        = '0;

        if (item.end_of_input)
        begin
            mode_next  = csvfs_pkg::MODE_LINE_START;
            field_next = '0;
            if (!at_line_start)
            begin
                res_valid       = 1'b1;
                res.field_index = field_reg;
                res.field_done  = 1'b1;
                res.line_done   = 1'b1;
            end
        end
        else if (cr_reg && (item.in_byte == csvfs_pkg::CH_LF))
        begin
            // Second half of a CR LF pair: swallowed.
            res_valid = 1'b0;
        end
        else if (b_is_eol)
        begin
            cr_next    = (item.in_byte == csvfs_pkg::CH_CR);
            mode_next  = csvfs_pkg::MODE_LINE_START;
            field_next = '0;
            res_valid  = 1'b1;
            res.line_done = 1'b1;
            if (at_line_start)
            begin
                res.empty_line = 1'b1;
            end
            else
            begin
                res.field_index = field_reg;
                res.field_done  = 1'b1;
            end
        end
        else
        begin
            res_valid       = 1'b1;
            res.field_index = field_reg;
            unique case (mode_reg)
                csvfs_pkg::MODE_PLAIN, csvfs_pkg::MODE_RAW:
                begin
                    if (b_is_sep)
                    begin
                        res.field_done = 1'b1;
                        field_next     = field_inc;
                        mode_next      = csvfs_pkg::MODE_FIELD_START;
                    end
                    else
                    begin
                        res.has_byte = 1'b1;
                        res.out_byte = item.in_byte;
                    end
                end
                csvfs_pkg::MODE_QUOTED:
                begin
                    if (b_is_quote)
                    begin
                        res_valid = 1'b0;
                        mode_next = csvfs_pkg::MODE_QUOTE_SEEN;
                    end
                    else
                    begin
                        res.has_byte = 1'b1;
                        res.out_byte = item.in_byte;
                    end
                end
                csvfs_pkg::MODE_QUOTE_SEEN:
                begin
                    if (b_is_quote)
                    begin
                        res.has_byte = 1'b1;
                        res.out_byte = item.in_byte;
                        mode_next    = csvfs_pkg::MODE_QUOTED;
                    end
                    else if (b_is_sep)
                    begin
                        res.field_done = 1'b1;
                        field_next     = field_inc;
                        mode_next      = csvfs_pkg::MODE_FIELD_START;
                    end
                    else
                    begin
                        res.has_byte = 1'b1;
                        res.out_byte = item.in_byte;
                        mode_next    = csvfs_pkg::MODE_RAW;
                    end
                end
                default:
                begin
                    // Line start, field start and the unused codes.
                    if (b_is_quote)
                    begin
                        res_valid = 1'b0;
                        mode_next = csvfs_pkg::MODE_QUOTED;
                    end
                    else if (b_is_sep)
                    begin
                        res.field_done = 1'b1;
                        field_next     = field_inc;
                        mode_next      = csvfs_pkg::MODE_FIELD_START;
                    end
                    else
                    begin
                        res.has_byte = 1'b1;
                        res.out_byte = item.in_byte;
                        mode_next    = csvfs_pkg::MODE_PLAIN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= csvfs_pkg::MODE_LINE_START;
            field_reg <= '0;
            cr_reg    <= 1'b0;
        end
        else if (step_go)
        begin
            mode_reg  <= mode_next;
            field_reg <= field_next;
            cr_reg    <= cr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_first_reg  <= csvfs_pkg::SEP_RESET;
            sep_second_reg <= csvfs_pkg::SEP_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == csvfs_pkg::REG_SEP_FIRST)
            begin
                sep_first_reg <= cfg_data;
            end
            else if (cfg_index == csvfs_pkg::REG_SEP_SECOND)
            begin
                sep_second_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/csvfs_out_stage.sv */
// Result register of the CSV field splitter: holds one result transaction.
// Depends on csvfs_pkg.
`default_nettype none

module csvfs_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step_go,
    input  wire logic               res_valid,
    input  wire csvfs_pkg::result_t res,
    output logic                    out_free,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output csvfs_pkg::result_t      res_held
);

    logic               vld_reg;
    csvfs_pkg::result_t res_reg;

    assign out_free = !vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (step_go)
        begin
            vld_reg <= res_valid;
        end
        else if (out_ready)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = vld_reg;
    assign res_held  = res_reg;

endmodule

`default_nettype wire

/* rtl/core/csv_field_splitter.sv */
// Top level of the CSV field splitter: input register, parser core, result register.
// Depends on csvfs_pkg, csvfs_in_stage, csvfs_core, csvfs_out_stage and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// The splitter takes a text stream one byte per input transaction and emits at
// most one result transaction per byte: a field data byte with its field index,
// a field end, a line end, or an empty-line marker. It sustains one byte per
// clock cycle while the result register is free or being drained. An accepted
// byte sits in the input register, the parser state is updated from it, and its
// result lands in the result register when the parser steps; the result reaches
// the outputs only from there. The input side keeps taking bytes while a result
// waits, as long as the result register is free or being drained in that cycle.
// A byte that yields no result (an opening quote, the LF of a CR LF pair, end of
// input at line start) still waits in the input register until the result
// register is free, because the parser only steps then.
// The separator registers are written through the configuration channel, which
// is always ready; write them only while no byte is in flight.
module csv_field_splitter (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input transactions.
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [csvfs_pkg::BYTE_W-1:0]        in_byte,
    input  wire logic                                end_of_input,
    // Result transactions.
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     has_byte,
    output logic [csvfs_pkg::BYTE_W-1:0]             out_byte,
    output logic [csvfs_pkg::FIELD_W-1:0]            field_index,
    output logic                                     field_done,
    output logic                                     line_done,
    output logic                                     empty_line,
    // Configuration writes.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [csvfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [csvfs_pkg::BYTE_W-1:0]        cfg_data
);

    csvfs_pkg::item_t   item_in;
    csvfs_pkg::item_t   item_held;
    csvfs_pkg::result_t res;
    csvfs_pkg::result_t res_held;
    logic               item_vld;
    logic               res_valid;
    logic               out_free;
    logic               step_go;

    assign item_in.in_byte      = in_byte;
    assign item_in.end_of_input = end_of_input;

    // A held byte is processed whenever the result register can take its result.
    assign step_go   = item_vld && out_free;
    assign cfg_ready = 1'b1;

    csvfs_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .item      (item_in),
        .step_go   (step_go),
        .item_vld  (item_vld),
        .item_held (item_held)
    );

    csvfs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_go   (step_go),
        .item      (item_held),
        .res_valid (res_valid),
        .res       (res)
    );

    csvfs_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_go   (step_go),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_held  (res_held)
    );

    assign has_byte    = res_held.has_byte;
    assign out_byte    = res_held.out_byte;
    assign field_index = res_held.field_index;
    assign field_done  = res_held.field_done;
    assign line_done   = res_held.line_done;
    assign empty_line  = res_held.empty_line;

    // The input side only stalls when a byte is held behind a blocked result.
    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, !in_ready, item_vld && out_valid && !out_ready)
    // An accepted byte is held in the input register in the next cycle.
    `ASSERT_NEXT(a_accept_held, clk, rst_n, in_valid && in_ready, item_vld)
    // A data byte never carries a field or line end.
    `ASSERT_IMPLY(a_byte_excl, clk, rst_n, out_valid && has_byte, !field_done && !line_done)
    // An empty-line marker is a bare line end at field index zero.
    `ASSERT_IMPLY(a_empty_line, clk, rst_n, out_valid && empty_line,
                  line_done && !field_done && !has_byte && (field_index == '0))

endmodule

`default_nettype wire

/* tb/sv/csv_field_splitter_tb.sv */
// Self-checking testbench for csv_field_splitter, the streaming CSV field and line splitter.
// Depends on csvfs_pkg for the port widths, character codes, register indexes and mode enum.
`timescale 1ns / 100ps

module csv_field_splitter_tb;

    // Clock, reset and the three channels of the block.
    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic [csvfs_pkg::BYTE_W-1:0]    in_byte;
    logic                            end_of_input;
    logic                            out_valid;
    logic                            out_ready;
    logic                            has_byte;
    logic [csvfs_pkg::BYTE_W-1:0]    out_byte;
    logic [csvfs_pkg::FIELD_W-1:0]   field_index;
    logic                            field_done;
    logic                            line_done;
    logic                            empty_line;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [csvfs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [csvfs_pkg::BYTE_W-1:0]    cfg_data;

    // The testbench's own copy of the splitter state and separator registers.
    csvfs_pkg::mode_t                split_mode;
    logic [csvfs_pkg::FIELD_W-1:0]   split_field;
    logic                            cr_pending;
    logic [csvfs_pkg::BYTE_W-1:0]    sep_a;
    logic [csvfs_pkg::BYTE_W-1:0]    sep_b;

    // Tokens the block still owes us, oldest first.
    csvfs_pkg::result_t              tokens_due[$];
    int                              mismatches;
    int                              bytes_sent;

    // Idling switches for the sender and the receiver.
    bit                              tx_idle_on;
    bit                              rx_idle_on;

    csv_field_splitter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .has_byte     (has_byte),
        .out_byte     (out_byte),
        .field_index  (field_index),
        .field_done   (field_done),
        .line_done    (line_done),
        .empty_line   (empty_line),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on the run. The slowest correct run stays far below this.
    initial
    begin
        #1500000;
        $display("== FAIL ==");
        $finish;
    end

    // Works out the token that one accepted byte produces, if any, and advances
    // the local parser state. Line ends are tested before anything else, so a
    // separator equal to CR or LF loses to them; outside plain and raw fields the
    // quote is tested before the separators, so there a quote separator loses too.
    function automatic bit tokenize_byte(input logic [csvfs_pkg::BYTE_W-1:0] b,
                                         input logic eoi,
                                         output csvfs_pkg::result_t tok);
        logic             was_cr;
        logic             at_sep;
        logic             ends_field;
        csvfs_pkg::mode_t next_mode;
        tok        = '0;
        was_cr     = cr_pending;
        cr_pending = 1'b0;
        at_sep     = (b == sep_a) || (b == sep_b);
        ends_field = 1'b0;
        next_mode  = split_mode;

        // End of input with no line open only clears the state.
        if (eoi && split_mode == csvfs_pkg::MODE_LINE_START)
        begin
            split_field = '0;
            return 1'b0;
        end
        // The LF of a CR LF pair is swallowed.
        if (!eoi && was_cr && b == csvfs_pkg::CH_LF)
            return 1'b0;
        if (eoi || b == csvfs_pkg::CH_CR || b == csvfs_pkg::CH_LF)
        begin
            cr_pending     = !eoi && (b == csvfs_pkg::CH_CR);
            tok.line_done  = 1'b1;
            if (split_mode == csvfs_pkg::MODE_LINE_START)
                tok.empty_line = 1'b1;
            else
            begin
                tok.field_done  = 1'b1;
                tok.field_index = split_field;
            end
            split_mode  = csvfs_pkg::MODE_LINE_START;
            split_field = '0;
            return 1'b1;
        end

        case (split_mode)
            csvfs_pkg::MODE_PLAIN, csvfs_pkg::MODE_RAW:
                ends_field = at_sep;
            csvfs_pkg::MODE_QUOTED:
            begin
                if (b == csvfs_pkg::CH_QUOTE)
                begin
                    split_mode = csvfs_pkg::MODE_QUOTE_SEEN;
                    return 1'b0;
                end
            end
            csvfs_pkg::MODE_QUOTE_SEEN:
            begin
                // A doubled quote is data, a separator closes the field, and
                // anything else starts the raw tail after the closing quote.
                if (b == csvfs_pkg::CH_QUOTE)
                    next_mode = csvfs_pkg::MODE_QUOTED;
                else if (at_sep)
                    ends_field = 1'b1;
                else
                    next_mode = csvfs_pkg::MODE_RAW;
            end
            default:
            begin
                if (b == csvfs_pkg::CH_QUOTE)
                begin
                    split_mode = csvfs_pkg::MODE_QUOTED;
                    return 1'b0;
                end
                ends_field = at_sep;
                next_mode  = csvfs_pkg::MODE_PLAIN;
            end
        endcase

        tok.field_index = split_field;
        if (ends_field)
        begin
            tok.field_done = 1'b1;
            if (split_field != '1)
                split_field = split_field + 1'b1;
            split_mode = csvfs_pkg::MODE_FIELD_START;
        end
        else
        begin
            tok.has_byte = 1'b1;
            tok.out_byte = b;
            split_mode   = next_mode;
        end
        return 1'b1;
    endfunction

    task automatic report_field(input string name, input int unsigned want_v,
                                input int unsigned got_v);
        $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
        mismatches++;
    endtask

    // Every result transaction is matched against the oldest owed token.
    always @(posedge clk)
    begin : check_tokens
        csvfs_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (tokens_due.size() == 0)
            begin
                $display("%0t ns: unexpected result transaction: expected none, actual %h",
                         $time, {has_byte, out_byte, field_index, field_done, line_done,
                                 empty_line});
                mismatches++;
            end
            else
            begin
                want = tokens_due.pop_front();
                if (has_byte !== want.has_byte)
                    report_field("has_byte", want.has_byte, has_byte);
                if (out_byte !== want.out_byte)
                    report_field("out_byte", want.out_byte, out_byte);
                if (field_index !== want.field_index)
                    report_field("field_index", want.field_index, field_index);
                if (field_done !== want.field_done)
                    report_field("field_done", want.field_done, field_done);
                if (line_done !== want.line_done)
                    report_field("line_done", want.line_done, line_done);
                if (empty_line !== want.empty_line)
                    report_field("empty_line", want.empty_line, empty_line);
            end
        end
    end

    // Receiver: out_ready drops in random bursts while idling is on.
    initial
    begin : drive_out_ready
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_idle_on && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(1, 12);
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Sends one input transaction, with an optional idle burst in front of it,
    // and records the token it should produce once the block has taken it.
    task automatic send_item(input logic [csvfs_pkg::BYTE_W-1:0] b, input logic eoi);
        int                 gap;
        csvfs_pkg::result_t tok;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        in_byte      <= b;
        end_of_input <= eoi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (tokenize_byte(b, eoi, tok))
            tokens_due.insert(tokens_due.size(), tok);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // Stops sending and waits until every owed token has come back. A byte that
    // gives no token can still be in the pipeline, so the wait goes on to let it drain.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [csvfs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [csvfs_pkg::BYTE_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == csvfs_pkg::REG_SEP_FIRST)
            sep_a = val;
        else if (idx == csvfs_pkg::REG_SEP_SECOND)
            sep_b = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [csvfs_pkg::BYTE_W-1:0] pick_sep();
        return ($urandom_range(0, 1) != 0) ? sep_a : sep_b;
    endfunction

    // A byte with no special meaning under the current separators.
    function automatic logic [csvfs_pkg::BYTE_W-1:0] plain_char();
        logic [csvfs_pkg::BYTE_W-1:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == csvfs_pkg::CH_CR || b == csvfs_pkg::CH_LF || b == csvfs_pkg::CH_QUOTE ||
               b == sep_a || b == sep_b);
        return b;
    endfunction

    function automatic logic [csvfs_pkg::BYTE_W-1:0] noise_byte();
        case ($urandom_range(0, 5))
            0:       return sep_a;
            1:       return sep_b;
            2:       return csvfs_pkg::CH_QUOTE;
            3:       return csvfs_pkg::CH_CR;
            4:       return csvfs_pkg::CH_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One well-formed record: plain and quoted fields with random content,
    // closed by LF, CR, CR LF or end of input.
    task automatic send_record();
        int n_fields;
        int len;
        n_fields = $urandom_range(0, 5);
        for (int f = 0; f < n_fields; f++)
        begin
            if (f != 0)
                send_item(pick_sep(), 1'b0);
            len = $urandom_range(0, 6);
            if ($urandom_range(0, 2) == 0)
            begin
                send_item(csvfs_pkg::CH_QUOTE, 1'b0);
                repeat (len)
                begin
                    case ($urandom_range(0, 5))
                        0: send_item(pick_sep(), 1'b0);
                        1:
                        begin
                            send_item(csvfs_pkg::CH_QUOTE, 1'b0);
                            send_item(csvfs_pkg::CH_QUOTE, 1'b0);
                        end
                        default: send_item(plain_char(), 1'b0);
                    endcase
                end
                send_item(csvfs_pkg::CH_QUOTE, 1'b0);
                // Sometimes a raw tail follows the closing quote.
                if ($urandom_range(0, 3) == 0)
                    send_item(plain_char(), 1'b0);
            end
            else
                repeat (len) send_item(plain_char(), 1'b0);
        end
        case ($urandom_range(0, 4))
            0: send_item(csvfs_pkg::CH_CR, 1'b0);
            1:
            begin
                send_item(csvfs_pkg::CH_CR, 1'b0);
                send_item(csvfs_pkg::CH_LF, 1'b0);
            end
            2: send_item(8'($urandom_range(0, 255)), 1'b1);
            default: send_item(csvfs_pkg::CH_LF, 1'b0);
        endcase
    endtask

    // Broken input: a short run of special and random bytes, now and then an end of input.
    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            send_item(noise_byte(), $urandom_range(0, 7) == 0);
    endtask

    // Hand-picked sequences under the reset separators: empty lines, CR LF,
    // quoted separators, doubled quotes, the raw tail, empty fields, a trailing
    // separator, a line end inside a quoted field, end of input in both modes,
    // end of input clearing a pending CR, and the byte extremes.
    task automatic test_directed_cases();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_text("\n");
        send_text("a,b\015\n");
        send_text("\"x,\"\"\"r,,\n");
        send_text("\"a\015");
        send_item(8'h00, 1'b1);
        send_text("\n");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        settle();
    endtask

    // Random records and noise under a series of separator settings, among them
    // the extremes, two different separators, and separators that clash with the
    // quote and line-end characters. The last setting runs without idling.
    task automatic test_random_records();
        logic [csvfs_pkg::BYTE_W-1:0] firsts [8];
        logic [csvfs_pkg::BYTE_W-1:0] seconds [8];
        int                           phase_base;
        firsts  = '{8'd44, 8'd44, 8'd9, 8'd0,   8'd255, csvfs_pkg::CH_QUOTE, csvfs_pkg::CH_LF,
                    8'd44};
        seconds = '{8'd44, 8'd59, 8'd9, 8'd255, 8'd0,   8'd124,              csvfs_pkg::CH_CR,
                    8'd44};
        for (int p = 0; p < 8; p++)
        begin
            write_reg(csvfs_pkg::REG_SEP_FIRST, firsts[p]);
            write_reg(csvfs_pkg::REG_SEP_SECOND, seconds[p]);
            phase_base = bytes_sent;
            tx_idle_on = (p != 7);
            rx_idle_on = (p != 7);
            while (bytes_sent - phase_base < 250)
            begin
                if (p != 7 && $urandom_range(0, 15) == 0)
                begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    rx_idle_on = ($urandom_range(0, 3) != 0);
                end
                if ($urandom_range(0, 4) == 0)
                    send_noise();
                else
                    send_record();
            end
            // The sender holds off here until every owed token has arrived,
            // which also makes the next register write safe.
            settle();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_byte      = '0;
        end_of_input = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = csvfs_pkg::REG_SEP_FIRST;
        cfg_data     = '0;
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        mismatches   = 0;
        bytes_sent   = 0;
        split_mode   = csvfs_pkg::MODE_LINE_START;
        split_field  = '0;
        cr_pending   = 1'b0;
        sep_a        = csvfs_pkg::SEP_RESET;
        sep_b        = csvfs_pkg::SEP_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_random_records();
        settle();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
